// File: rtl/segi_pkg.sv
// Shared widths, types and limits for the segment intersection pipeline.
package segi_pkg;
   localparam int COORD_W = 24;
   localparam int DIFF_W  = COORD_W + 1;        // coordinate difference
   localparam int PROD_W  = 2 * DIFF_W;         // product of two differences
   localparam int CPRD_W  = 2 * COORD_W;        // product of two coordinates
   localparam int CRS_W   = CPRD_W + 1;         // c1, c2
   localparam int DEN_W   = PROD_W + 1;         // den, t and u numerators
   localparam int NUM_W   = 76;                 // point numerator
   localparam int QUOT_W  = COORD_W;            // quotient bits developed
   localparam int DIV_LAT = QUOT_W + 3;         // divider latency in cycles
   localparam int REQ_W   = 8 * COORD_W;
   localparam int RSP_W   = 56;

   localparam logic signed [COORD_W-1:0] COORD_MAX = {1'b0, {(COORD_W-1){1'b1}}};
   localparam logic signed [COORD_W-1:0] COORD_MIN = {1'b1, {(COORD_W-1){1'b0}}};

   typedef logic signed [COORD_W-1:0] coord_type;
   typedef logic signed [DIFF_W-1:0]  diff_type;
   typedef logic signed [PROD_W-1:0]  prod_type;
   typedef logic signed [DEN_W-1:0]   den_type;
   typedef logic signed [NUM_W-1:0]   num_type;
endpackage

// File: rtl/segment_intersection.sv
// Segment intersection: a fully pipelined 2D segment-pair test with line crossing point.
//
// One segment pair per cycle enters while the pipeline advances, and leaves as one result.
// Six arithmetic stages form the differences, cross products and point numerators,
// and a 27-stage divider (one quotient bit per step stage, two lanes) forms the point.
// The whole pipeline advances whenever the output register is empty or taken,
// so throughput is one request per cycle while rsp_tready stays high.
// Parallel pairs report parallel=1, hit=0 and a zero point.
module segment_intersection import segi_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   // seg_a_start_x, seg_a_start_y, seg_a_end_x, seg_a_end_y,
   // seg_b_start_x, seg_b_start_y, seg_b_end_x, seg_b_end_y (24 bits each)
   input  logic [REQ_W-1:0] req_tdata,
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   // hit, parallel, point_x[24], point_y[24], point_overflow, zero pad
   output logic [RSP_W-1:0] rsp_tdata
);
   localparam int SIDE_N = DIV_LAT;

   logic en;
   assign en         = !rsp_tvalid || rsp_tready;
   assign req_tready = en;

   coord_type ax0, ay0, ax1, ay1, bx0, by0, bx1, by1;
   assign ax0 = req_tdata[0*COORD_W +: COORD_W];
   assign ay0 = req_tdata[1*COORD_W +: COORD_W];
   assign ax1 = req_tdata[2*COORD_W +: COORD_W];
   assign ay1 = req_tdata[3*COORD_W +: COORD_W];
   assign bx0 = req_tdata[4*COORD_W +: COORD_W];
   assign by0 = req_tdata[5*COORD_W +: COORD_W];
   assign bx1 = req_tdata[6*COORD_W +: COORD_W];
   assign by1 = req_tdata[7*COORD_W +: COORD_W];

   // stage 1: differences, raw coordinates
   diff_type  rx_ff, ry_ff, sx_ff, sy_ff, qx_ff, qy_ff;
   diff_type  mbx_ff, mby_ff, max_ff, may_ff;
   coord_type ax0_ff, ay0_ff, ax1_ff, ay1_ff, bx0_ff, by0_ff, bx1_ff, by1_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         rx_ff  <= DIFF_W'(ax1) - DIFF_W'(ax0);
         ry_ff  <= DIFF_W'(ay1) - DIFF_W'(ay0);
         sx_ff  <= DIFF_W'(bx1) - DIFF_W'(bx0);
         sy_ff  <= DIFF_W'(by1) - DIFF_W'(by0);
         qx_ff  <= DIFF_W'(bx0) - DIFF_W'(ax0);
         qy_ff  <= DIFF_W'(by0) - DIFF_W'(ay0);
         mbx_ff <= DIFF_W'(bx0) - DIFF_W'(bx1);
         mby_ff <= DIFF_W'(by0) - DIFF_W'(by1);
         max_ff <= DIFF_W'(ax0) - DIFF_W'(ax1);
         may_ff <= DIFF_W'(ay0) - DIFF_W'(ay1);
         ax0_ff <= ax0;
         ay0_ff <= ay0;
         ax1_ff <= ax1;
         ay1_ff <= ay1;
         bx0_ff <= bx0;
         by0_ff <= by0;
         bx1_ff <= bx1;
         by1_ff <= by1;
      end
   end

   // stage 2: cross-product terms
   prod_type p_rs_ff, p_sr_ff, p_qs_ff, p_sq_ff, p_qr_ff, p_rq_ff;
   logic signed [CPRD_W-1:0] pa1_ff, pa2_ff, pb1_ff, pb2_ff;
   diff_type mbx2_ff, mby2_ff, max2_ff, may2_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         p_rs_ff <= rx_ff * sy_ff;
         p_sr_ff <= ry_ff * sx_ff;
         p_qs_ff <= qx_ff * sy_ff;
         p_sq_ff <= qy_ff * sx_ff;
         p_qr_ff <= qx_ff * ry_ff;
         p_rq_ff <= qy_ff * rx_ff;
         pa1_ff  <= ax0_ff * ay1_ff;
         pa2_ff  <= ay0_ff * ax1_ff;
         pb1_ff  <= bx0_ff * by1_ff;
         pb2_ff  <= by0_ff * bx1_ff;
         mbx2_ff <= mbx_ff;
         mby2_ff <= mby_ff;
         max2_ff <= max_ff;
         may2_ff <= may_ff;
      end
   end

   // stage 3: den, t and u numerators, c1, c2
   den_type den3_ff, tn_ff, un_ff;
   logic signed [CRS_W-1:0] c1_ff, c2_ff;
   diff_type mbx3_ff, mby3_ff, max3_ff, may3_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         den3_ff <= DEN_W'(p_rs_ff) - DEN_W'(p_sr_ff);
         tn_ff   <= DEN_W'(p_qs_ff) - DEN_W'(p_sq_ff);
         un_ff   <= DEN_W'(p_qr_ff) - DEN_W'(p_rq_ff);
         c1_ff   <= CRS_W'(pa1_ff) - CRS_W'(pa2_ff);
         c2_ff   <= CRS_W'(pb1_ff) - CRS_W'(pb2_ff);
         mbx3_ff <= mbx2_ff;
         mby3_ff <= mby2_ff;
         max3_ff <= max2_ff;
         may3_ff <= may2_ff;
      end
   end

   // stage 4: range test, split partial products of the point numerators
   diff_type c1h, c1l, c2h, c2l;
   logic     t_in, u_in;
   assign c1h = c1_ff[CRS_W-1:COORD_W];
   assign c1l = {1'b0, c1_ff[COORD_W-1:0]};
   assign c2h = c2_ff[CRS_W-1:COORD_W];
   assign c2l = {1'b0, c2_ff[COORD_W-1:0]};

   always_comb begin
      if (!den3_ff[DEN_W-1]) begin
         t_in = !tn_ff[DEN_W-1] && (tn_ff <= den3_ff);
         u_in = !un_ff[DEN_W-1] && (un_ff <= den3_ff);
      end else begin
         t_in = (tn_ff <= 0) && (tn_ff >= den3_ff);
         u_in = (un_ff <= 0) && (un_ff >= den3_ff);
      end
   end

   prod_type xh1_ff, xl1_ff, xh2_ff, xl2_ff, yh1_ff, yl1_ff, yh2_ff, yl2_ff;
   den_type  den4_ff;
   logic     hit4_ff, par4_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         xh1_ff  <= c1h * mbx3_ff;
         xl1_ff  <= c1l * mbx3_ff;
         xh2_ff  <= c2h * max3_ff;
         xl2_ff  <= c2l * max3_ff;
         yh1_ff  <= c1h * mby3_ff;
         yl1_ff  <= c1l * mby3_ff;
         yh2_ff  <= c2h * may3_ff;
         yl2_ff  <= c2l * may3_ff;
         den4_ff <= den3_ff;
         par4_ff <= den3_ff == '0;
         hit4_ff <= (den3_ff != '0) && t_in && u_in;
      end
   end

   // stage 5: high and low differences
   den_type xh_ff, xl_ff, yh_ff, yl_ff, den5_ff;
   logic    hit5_ff, par5_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         xh_ff   <= DEN_W'(xh1_ff) - DEN_W'(xh2_ff);
         xl_ff   <= DEN_W'(xl1_ff) - DEN_W'(xl2_ff);
         yh_ff   <= DEN_W'(yh1_ff) - DEN_W'(yh2_ff);
         yl_ff   <= DEN_W'(yl1_ff) - DEN_W'(yl2_ff);
         den5_ff <= den4_ff;
         hit5_ff <= hit4_ff;
         par5_ff <= par4_ff;
      end
   end

   // stage 6: full point numerators
   num_type nx_ff, ny_ff;
   den_type den6_ff;
   logic    hit6_ff, par6_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         nx_ff   <= (NUM_W'(xh_ff) <<< COORD_W) + NUM_W'(xl_ff);
         ny_ff   <= (NUM_W'(yh_ff) <<< COORD_W) + NUM_W'(yl_ff);
         den6_ff <= den5_ff;
         hit6_ff <= hit5_ff;
         par6_ff <= par5_ff;
      end
   end

   // divider lanes
   coord_type qx, qy;
   logic      ovx, ovy;

   segi_div u_div_x (
      .clock (clock), .en (en), .num_i (nx_ff), .den_i (den6_ff),
      .quot_o (qx), .ovf_o (ovx)
   );
   segi_div u_div_y (
      .clock (clock), .en (en), .num_i (ny_ff), .den_i (den6_ff),
      .quot_o (qy), .ovf_o (ovy)
   );

   // flags travel beside the divider
   logic hit_ff [0:SIDE_N-1];
   logic par_ff [0:SIDE_N-1];

   always_ff @(posedge clock) begin
      if (en) begin
         hit_ff[0] <= hit6_ff;
         par_ff[0] <= par6_ff;
         for (int i = 1; i < SIDE_N; i++) begin
            hit_ff[i] <= hit_ff[i-1];
            par_ff[i] <= par_ff[i-1];
         end
      end
   end

   // valid bits, six arithmetic stages plus the divider
   localparam int VLD_N = 6 + SIDE_N;
   logic [VLD_N-1:0] vld_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[VLD_N-2:0], req_tvalid};
      end
   end

   assign rsp_tvalid = vld_ff[VLD_N-1];

   // output packing; parallel pairs give a zero point
   logic par_o;
   assign par_o = par_ff[SIDE_N-1];
   assign rsp_tdata = {
      {(RSP_W - 3 - 2*COORD_W){1'b0}},
      !par_o && (ovx || ovy),
      par_o ? coord_type'(0) : qy,
      par_o ? coord_type'(0) : qx,
      par_o,
      hit_ff[SIDE_N-1]
   };
endmodule

// File: rtl/segi_div.sv
// Pipelined signed divider: numerator over den, truncated, saturated to a coordinate.
module segi_div import segi_pkg::*; (
   input  logic      clock,
   input  logic      en,
   input  num_type   num_i,
   input  den_type   den_i,
   output coord_type quot_o,
   output logic      ovf_o
);
   // stage A: magnitudes and result sign
   logic [NUM_W-1:0] mag_ff;
   logic [DEN_W-1:0] dmag_ff;
   logic             nega_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         mag_ff  <= num_i[NUM_W-1] ? NUM_W'(-num_i) : NUM_W'(num_i);
         dmag_ff <= den_i[DEN_W-1] ? DEN_W'(-den_i) : DEN_W'(den_i);
         nega_ff <= num_i[NUM_W-1] ^ den_i[DEN_W-1];
      end
   end

   // stage B loads the remainder; each stage after it develops one quotient bit
   logic [DEN_W-1:0]  rem_ff [0:QUOT_W];
   logic [QUOT_W-1:0] low_ff [0:QUOT_W];
   logic [QUOT_W-1:0] q_ff   [0:QUOT_W];
   logic [DEN_W-1:0]  d_ff   [0:QUOT_W];
   logic              neg_ff [0:QUOT_W];
   logic              big_ff [0:QUOT_W];

   // quotient of 2^QUOT_W or more always saturates
   always_ff @(posedge clock) begin
      if (en) begin
         big_ff[0] <= mag_ff[NUM_W-1:QUOT_W] >= {1'b0, dmag_ff};
         rem_ff[0] <= mag_ff[NUM_W-2:QUOT_W];
         low_ff[0] <= mag_ff[QUOT_W-1:0];
         q_ff[0]   <= '0;
         d_ff[0]   <= dmag_ff;
         neg_ff[0] <= nega_ff;
      end
   end

   for (genvar k = 0; k < QUOT_W; k++) begin : g_step
      logic [DEN_W:0] trial;
      logic           ge;
      assign trial = {rem_ff[k], low_ff[k][QUOT_W-1]};
      assign ge    = trial >= {1'b0, d_ff[k]};
      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[k+1] <= ge ? DEN_W'(trial - {1'b0, d_ff[k]}) : trial[DEN_W-1:0];
            low_ff[k+1] <= {low_ff[k][QUOT_W-2:0], 1'b0};
            q_ff[k+1]   <= {q_ff[k][QUOT_W-2:0], ge};
            d_ff[k+1]   <= d_ff[k];
            neg_ff[k+1] <= neg_ff[k];
            big_ff[k+1] <= big_ff[k];
         end
      end
   end

   // final stage: sign and saturation
   logic [QUOT_W-1:0] qf;
   logic              negf;
   logic              ovf_in;
   coord_type         quot_in;
   coord_type         quot_ff;
   logic              ovf_ff;

   always_comb begin
      qf     = q_ff[QUOT_W];
      negf   = neg_ff[QUOT_W];
      ovf_in = big_ff[QUOT_W] ||
               (negf ? (qf[QUOT_W-1] && (qf[QUOT_W-2:0] != '0)) : qf[QUOT_W-1]);
      if (ovf_in) begin
         quot_in = negf ? COORD_MIN : COORD_MAX;
      end else begin
         quot_in = negf ? coord_type'(-qf) : coord_type'(qf);
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         quot_ff <= quot_in;
         ovf_ff  <= ovf_in;
      end
   end

   assign quot_o = quot_ff;
   assign ovf_o  = ovf_ff;
endmodule

// File: rtl/segi_checker.sv
// Port-level checks for the segment intersection block, bound to the top level.
module segi_checker import segi_pkg::*; (
   input logic             clock,
   input logic             reset,
   input logic             rsp_tvalid,
   input logic             rsp_tready,
   input logic [RSP_W-1:0] rsp_tdata
);
   logic      hit, par, ovf;
   coord_type px, py;
   assign hit = rsp_tdata[0];
   assign par = rsp_tdata[1];
   assign px  = rsp_tdata[2 +: COORD_W];
   assign py  = rsp_tdata[2 + COORD_W +: COORD_W];
   assign ovf = rsp_tdata[2 + 2*COORD_W];

   // stalled response holds
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("response changed under stall");

   // parallel pairs report nothing else
   a_par: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && par |-> !hit && !ovf && px == '0 && py == '0)
      else $error("parallel response carries data");

   // overflow means a coordinate sits at a limit
   a_ovf: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && ovf |-> px == COORD_MAX || px == COORD_MIN ||
                            py == COORD_MAX || py == COORD_MIN)
      else $error("overflow without saturated coordinate");

   // pipeline empties on reset
   a_rst: assert property (@(posedge clock) $past(reset) |-> !rsp_tvalid)
      else $error("response valid right after reset");
endmodule

bind segment_intersection segi_checker u_segi_checker (
   .clock (clock), .reset (reset), .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready), .rsp_tdata (rsp_tdata)
);
